// ----- design/fpw_pkg.sv -----
// Shared types, field widths and codes of the five-level page table walker.
package fpw_pkg;

  localparam int ActW       = 2;
  localparam int VpnW       = 45;
  localparam int PpnW       = 52;
  localparam int StatusW    = 2;
  localparam int EntryW     = PpnW + 1;   // {frame, valid}
  localparam int RootW      = 6;
  localparam int FirstFreeW = 7;
  localparam int CfgDataW   = 7;
  localparam int CfgIdxW    = 1;

  // action codes
  localparam logic [ActW-1:0] ActQuery = 2'd0;
  localparam logic [ActW-1:0] ActMap   = 2'd1;
  localparam logic [ActW-1:0] ActUnmap = 2'd2;
  localparam logic [ActW-1:0] ActNone  = 2'd3;

  // status codes
  localparam logic [StatusW-1:0] StsOk    = 2'd0;
  localparam logic [StatusW-1:0] StsNoMap = 2'd1;
  localparam logic [StatusW-1:0] StsFull  = 2'd2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgRootFrame = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgFirstFree = 1'b1;

  typedef struct packed {
    logic [ActW-1:0] action;
    logic [VpnW-1:0] vpn;
    logic [PpnW-1:0] ppn;
  } in_beat_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [PpnW-1:0]    ppn_out;
  } out_beat_t;

  // controller -> datapath
  typedef struct packed {
    logic               clr_step;   // write zero at the clear pointer
    logic               start;      // latch the input beat, point at the root
    logic               descend;    // follow the valid entry one level down
    logic               alloc;      // fill the missing entry from the allocator, go down
    logic               wr_leaf;    // write (map) or clear (unmap) the leaf
    logic               res_load;
    logic [StatusW-1:0] res_status;
    logic               res_found;  // take ppn_out from the entry just read
    logic               out_load;
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [ActW-1:0] act;
    logic            leaf;
    logic            ent_valid;
    logic            alloc_empty;
    logic            clr_last;
    logic            out_free;
  } ctl_sts_t;

endpackage

// ----- design/fpw_datapath.sv -----
// Walker datapath: frame memory, walk registers, allocator, config and result registers.
module fpw_datapath #(
  parameter int FRAMES     = 64,
  parameter int LEVELS     = 5,
  parameter int INDEX_BITS = 9
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [fpw_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [fpw_pkg::CfgDataW-1:0] cfg_data_i,
  input  fpw_pkg::in_beat_t            in_data_i,
  output fpw_pkg::out_beat_t           out_data_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  input  fpw_pkg::ctl_cmd_t            cmd_i,
  output fpw_pkg::ctl_sts_t            sts_o
);

  localparam int FrameW = (FRAMES > 2) ? $clog2(FRAMES) : 1;
  localparam int AddrW  = FrameW + INDEX_BITS;
  localparam int Depth  = FRAMES << INDEX_BITS;
  localparam int LvW    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int ShW    = LEVELS * INDEX_BITS;
  localparam int TopSh  = (LEVELS - 1) * INDEX_BITS;
  localparam int VxW    = (ShW > fpw_pkg::VpnW) ? ShW : fpw_pkg::VpnW;
  localparam int NfW    = ($clog2(FRAMES + 1) > fpw_pkg::FirstFreeW) ?
                          $clog2(FRAMES + 1) : fpw_pkg::FirstFreeW;
  localparam int RootXW = (FrameW > fpw_pkg::RootW) ? FrameW : fpw_pkg::RootW;

  logic [fpw_pkg::EntryW-1:0] mem [Depth];

  logic [fpw_pkg::RootW-1:0]   root_q;
  logic [NfW-1:0]              nf_q, nf_d;
  logic [fpw_pkg::ActW-1:0]    act_q;
  logic [ShW-1:0]              sh_q, sh_d;
  logic [fpw_pkg::PpnW-1:0]    ppn_q;
  logic [FrameW-1:0]           frame_q, frame_d;
  logic [LvW-1:0]              lvl_q, lvl_d;
  logic [AddrW-1:0]            clr_q;
  logic [fpw_pkg::EntryW-1:0]  rdata_q;
  logic [fpw_pkg::StatusW-1:0] res_status_q;
  logic [fpw_pkg::PpnW-1:0]    res_ppn_q;
  fpw_pkg::out_beat_t          out_q;
  logic                        out_valid_q, out_valid_d;

  logic [VxW-1:0]              vpn_x;
  logic [RootXW-1:0]           root_x;
  logic [AddrW-1:0]            walk_addr, wr_addr;
  logic [fpw_pkg::EntryW-1:0]  wr_data;
  logic                        wr_en;

  assign vpn_x     = VxW'(in_data_i.vpn);
  assign root_x    = RootXW'(root_q);
  assign walk_addr = {frame_q, sh_q[TopSh +: INDEX_BITS]};

  always_comb begin
    wr_en   = cmd_i.clr_step | cmd_i.alloc | cmd_i.wr_leaf;
    wr_addr = cmd_i.clr_step ? clr_q : walk_addr;
    if (cmd_i.alloc) begin
      wr_data = {fpw_pkg::PpnW'(nf_q), 1'b1};
    end else if (cmd_i.wr_leaf && act_q == fpw_pkg::ActMap) begin
      wr_data = {ppn_q, 1'b1};
    end else begin
      wr_data = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_q <= mem[walk_addr];
  end

  // walk registers
  always_comb begin
    frame_d = frame_q;
    sh_d    = sh_q;
    lvl_d   = lvl_q;
    if (cmd_i.start) begin
      frame_d = root_x[FrameW-1:0];
      sh_d    = vpn_x[ShW-1:0];
      lvl_d   = LvW'(LEVELS - 1);
    end else if (cmd_i.descend || cmd_i.alloc) begin
      frame_d = cmd_i.alloc ? nf_q[FrameW-1:0] : rdata_q[FrameW:1];
      sh_d    = sh_q << INDEX_BITS;
      lvl_d   = lvl_q - LvW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    frame_q <= frame_d;
    sh_q    <= sh_d;
    lvl_q   <= lvl_d;
    if (cmd_i.start) begin
      act_q <= in_data_i.action;
      ppn_q <= in_data_i.ppn;
    end
    if (cmd_i.res_load) begin
      res_status_q <= cmd_i.res_status;
      res_ppn_q    <= cmd_i.res_found ? rdata_q[fpw_pkg::EntryW-1:1] : '0;
    end
    if (cmd_i.out_load) begin
      out_q.status  <= res_status_q;
      out_q.ppn_out <= res_ppn_q;
    end
  end

  // allocator pointer: reload on a config write, step on an allocation
  always_comb begin
    nf_d = nf_q;
    if (cfg_we_i && cfg_idx_i == fpw_pkg::CfgFirstFree) begin
      nf_d = NfW'(cfg_data_i);
    end else if (cmd_i.alloc) begin
      nf_d = nf_q + NfW'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q      <= '0;
      nf_q        <= NfW'(1);
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          fpw_pkg::CfgRootFrame: root_q <= cfg_data_i[fpw_pkg::RootW-1:0];
          fpw_pkg::CfgFirstFree: ;
          default: ;
        endcase
      end
      nf_q <= nf_d;
      if (cmd_i.clr_step) begin
        clr_q <= clr_q + AddrW'(1);
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    sts_o.act         = act_q;
    sts_o.leaf        = (lvl_q == '0);
    sts_o.ent_valid   = rdata_q[0];
    sts_o.alloc_empty = (nf_q >= NfW'(FRAMES));
    sts_o.clr_last    = (clr_q == {AddrW{1'b1}});
    sts_o.out_free    = !out_valid_q || !out_stall_i;
  end

  assign out_data_o  = out_q;
  assign out_valid_o = out_valid_q;

  a_nf_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cfg_we_i |=> nf_q >= $past(nf_q))
    else $error("allocator pointer moved backwards without a reload");

  a_out_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |=> out_valid_q && out_q.status == $past(res_status_q))
    else $error("result register not loaded");

endmodule

// ----- design/fpw_ctrl.sv -----
// Walker controller: clearing pass, accept, per-level read/check sequencing, result handoff.
module fpw_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  fpw_pkg::ctl_sts_t sts_i,
  output fpw_pkg::ctl_cmd_t cmd_o
);

  localparam logic [2:0] StClear = 3'd0;
  localparam logic [2:0] StIdle  = 3'd1;
  localparam logic [2:0] StRead  = 3'd2;
  localparam logic [2:0] StCheck = 3'd3;
  localparam logic [2:0] StFin   = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StClear: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = StRead;
        end
      end
      StRead: begin
        // read data of the current level lands in the next cycle
        state_d = StCheck;
      end
      StCheck: begin
        state_d             = StFin;
        cmd_o.res_load      = 1'b1;
        cmd_o.res_status    = fpw_pkg::StsOk;
        if (sts_i.act == fpw_pkg::ActNone) begin
          cmd_o.res_status = fpw_pkg::StsOk;
        end else if (sts_i.leaf) begin
          if (sts_i.act == fpw_pkg::ActQuery) begin
            cmd_o.res_found  = sts_i.ent_valid;
            cmd_o.res_status = sts_i.ent_valid ? fpw_pkg::StsOk : fpw_pkg::StsNoMap;
          end else begin
            cmd_o.wr_leaf = 1'b1;
          end
        end else if (sts_i.ent_valid) begin
          cmd_o.res_load = 1'b0;
          cmd_o.descend  = 1'b1;
          state_d        = StRead;
        end else if (sts_i.act == fpw_pkg::ActQuery) begin
          cmd_o.res_status = fpw_pkg::StsNoMap;
        end else if (sts_i.act == fpw_pkg::ActMap) begin
          if (sts_i.alloc_empty) begin
            cmd_o.res_status = fpw_pkg::StsFull;
          end else begin
            cmd_o.res_load = 1'b0;
            cmd_o.alloc    = 1'b1;
            state_d        = StRead;
          end
        end
        // unmap with a missing path ends with status ok
      end
      StFin: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != StIdle);

  a_accept_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> state_q == StRead)
    else $error("accepted beat did not start a walk");

  a_leaf_write_at_leaf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.wr_leaf |-> sts_i.leaf && $past(state_q) == StRead)
    else $error("leaf write away from level zero");

  a_alloc_has_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.alloc |-> !sts_i.alloc_empty && sts_i.act == fpw_pkg::ActMap)
    else $error("allocation without a free frame");

endmodule

// ----- design/five_level_page_table_walker.sv -----
// Top level of the five-level page table walker.
//
//  port group   dir  handshake                 beat
//  cfg_*        in   cfg_we_i                  cfg_idx_i, cfg_data_i
//  in_*         in   in_valid_i / in_stall_o   in_data_i  (action, vpn, ppn)
//  out_*        out  out_valid_o / out_stall_i out_data_o (status, ppn_out)
//
// One request at a time. A full walk does a frame memory read with registered data, then
// a check/write, on each level, between the accept and the handoff state; an early stop
// is shorter. After reset a clearing pass zeroes the frame memory, one entry a cycle,
// all FRAMES << INDEX_BITS entries (32768 by default); in_stall_o stays high meanwhile,
// config writes are taken. A stalled result holds in the output register while the
// next beat is accepted; the next walk then waits at its end for the register to free.
// FRAMES must be a power of two.
module five_level_page_table_walker #(
  parameter int FRAMES     = 64,
  parameter int LEVELS     = 5,
  parameter int INDEX_BITS = 9
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [fpw_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [fpw_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  fpw_pkg::in_beat_t            in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output fpw_pkg::out_beat_t           out_data_o
);

  fpw_pkg::ctl_cmd_t cmd;
  fpw_pkg::ctl_sts_t sts;

  fpw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fpw_datapath #(
    .FRAMES     (FRAMES),
    .LEVELS     (LEVELS),
    .INDEX_BITS (INDEX_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .out_data_o  (out_data_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule
